[hdl/tsmv_pkg.sv]
// ----------------------------------------------------------------------------
// tsmv_pkg
// Shared widths, register indexes, reset values and types of the voter.
// ----------------------------------------------------------------------------
package tsmv_pkg;

  localparam int VAL_W     = 24;   // one reading, 1/1024 hPa
  localparam int SUM_W     = 26;   // sum of three readings
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * SUM_W;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIV_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX = 2'd2;

  localparam logic [VAL_W-1:0] DIV_LIMIT_RST = 24'd1024;
  localparam logic [VAL_W-1:0] VALID_MIN_RST = 24'd307200;
  localparam logic [VAL_W-1:0] VALID_MAX_RST = 24'd1228800;

  // floor(x / 3) = (x * RECIP3) >> RECIP_SHIFT, exact for any x below 2^26
  localparam logic [SUM_W-1:0] RECIP3      = 26'd44739243;
  localparam int               RECIP_SHIFT = 27;

  // how the final sum is scaled; in the sort stage DIV_THREE marks a
  // full three-way vote still waiting for its gap test
  typedef enum logic [1:0] {
    DIV_NONE  = 2'd0,   // no valid reading: zero, failure flagged
    DIV_ONE   = 2'd1,
    DIV_TWO   = 2'd2,
    DIV_THREE = 2'd3
  } scale_t;

  typedef struct packed {
    scale_t            scale;
    logic [SUM_W-1:0]  sum;
  } vote_t;

endpackage

[hdl/triple_sensor_majority_voter.sv]
// ----------------------------------------------------------------------------
// triple_sensor_majority_voter
// Fuses three redundant pressure readings into one voted value.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_stall is low and returns one
// result per request through four register stages: the per-sensor window
// check, the sort of the valid readings, the divergence test with the
// sum, and the divide by three done as a reciprocal multiply. Stages
// only hold back when the stage after them is full and stalled, so a
// stalled output does not block requests until the pipeline fills.
// Registers are written on cfg_we and should only change while no
// request is in flight; an index of three is ignored. With no reading
// in the window the result is zero with out_read_failed set.
module triple_sensor_majority_voter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tsmv_pkg::VAL_W-1:0] in_pressure_a,
  input  logic [tsmv_pkg::VAL_W-1:0] in_pressure_b,
  input  logic [tsmv_pkg::VAL_W-1:0] in_pressure_c,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tsmv_pkg::VAL_W-1:0] out_fused_pressure,
  output logic                       out_read_failed,
  input  logic                       cfg_we,
  input  logic [tsmv_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tsmv_pkg::VAL_W-1:0] cfg_wdata
);
  import tsmv_pkg::*;

  logic [VAL_W-1:0] div_limit_r, valid_min_r, valid_max_r;
  logic             s1_vld_r, s1_load, s1_stall;
  logic [VAL_W-1:0] val_a, val_b, val_c;
  logic             ok_a, ok_b, ok_c;
  logic             mg_vld, mg_stall;
  vote_t            mg_vote;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_limit_r <= DIV_LIMIT_RST;
      valid_min_r <= VALID_MIN_RST;
      valid_max_r <= VALID_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DIV_LIMIT: div_limit_r <= cfg_wdata;
        REG_VALID_MIN: valid_min_r <= cfg_wdata;
        REG_VALID_MAX: valid_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_load  = !s1_vld_r || !s1_stall;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_load) begin
      s1_vld_r <= in_valid;
    end
  end

  tsmv_lane u_lane_a (
    .clk       (clk),
    .load      (s1_load),
    .pressure  (in_pressure_a),
    .valid_min (valid_min_r),
    .valid_max (valid_max_r),
    .value_r   (val_a),
    .ok_r      (ok_a)
  );

  tsmv_lane u_lane_b (
    .clk       (clk),
    .load      (s1_load),
    .pressure  (in_pressure_b),
    .valid_min (valid_min_r),
    .valid_max (valid_max_r),
    .value_r   (val_b),
    .ok_r      (ok_b)
  );

  tsmv_lane u_lane_c (
    .clk       (clk),
    .load      (s1_load),
    .pressure  (in_pressure_c),
    .valid_min (valid_min_r),
    .valid_max (valid_max_r),
    .value_r   (val_c),
    .ok_r      (ok_c)
  );

  tsmv_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s1_vld_r),
    .in_stall  (s1_stall),
    .val_a     (val_a),
    .val_b     (val_b),
    .val_c     (val_c),
    .ok_mask   ({ok_a, ok_b, ok_c}),
    .div_limit (div_limit_r),
    .out_vld   (mg_vld),
    .out_stall (mg_stall),
    .out_vote  (mg_vote)
  );

  tsmv_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (mg_vld),
    .in_stall  (mg_stall),
    .vote      (mg_vote),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .fused_r   (out_fused_pressure),
    .failed_r  (out_read_failed)
  );

endmodule

[hdl/tsmv_lane.sv]
// ----------------------------------------------------------------------------
// tsmv_lane
// One sensor lane: registers the reading and its window check.
// ----------------------------------------------------------------------------
module tsmv_lane (
  input  logic                       clk,
  input  logic                       load,
  input  logic [tsmv_pkg::VAL_W-1:0] pressure,
  input  logic [tsmv_pkg::VAL_W-1:0] valid_min,
  input  logic [tsmv_pkg::VAL_W-1:0] valid_max,
  output logic [tsmv_pkg::VAL_W-1:0] value_r,
  output logic                       ok_r
);
  import tsmv_pkg::*;

  logic ok_nxt;

  // both bounds inclusive; an inverted window passes nothing
  assign ok_nxt = (pressure >= valid_min) && (pressure <= valid_max);

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= pressure;
      ok_r    <= ok_nxt;
    end
  end

endmodule

[hdl/tsmv_merge.sv]
// ----------------------------------------------------------------------------
// tsmv_merge
// Merges the lane results: sorts the valid readings, applies the
// divergence test and forms the sum to be scaled.
// ----------------------------------------------------------------------------
module tsmv_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  output logic                       in_stall,
  input  logic [tsmv_pkg::VAL_W-1:0] val_a,
  input  logic [tsmv_pkg::VAL_W-1:0] val_b,
  input  logic [tsmv_pkg::VAL_W-1:0] val_c,
  input  logic [2:0]                 ok_mask,
  input  logic [tsmv_pkg::VAL_W-1:0] div_limit,
  output logic                       out_vld,
  input  logic                       out_stall,
  output tsmv_pkg::vote_t            out_vote
);
  import tsmv_pkg::*;

  localparam logic [2:0] MASK_ALL = 3'b111;
  localparam logic [2:0] MASK_AB  = 3'b110;
  localparam logic [2:0] MASK_AC  = 3'b101;
  localparam logic [2:0] MASK_BC  = 3'b011;
  localparam logic [2:0] MASK_A   = 3'b100;
  localparam logic [2:0] MASK_B   = 3'b010;
  localparam logic [2:0] MASK_C   = 3'b001;

  logic             s2_vld_r, s3_vld_r;
  logic             s2_load, s3_load;
  logic [VAL_W-1:0] p0_r, p1_r, p2_r;
  logic [VAL_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  scale_t           s2_scale_r, s2_scale_nxt;
  vote_t            vote_r, vote_nxt;
  logic             gt_ab, gt_bc, gt_ac;
  logic [VAL_W-1:0] lo, mid, hi;
  logic             gap_lo, gap_hi;
  logic [SUM_W-1:0] sum_up, sum_dn, sum_all;

  assign s3_load  = !s3_vld_r || !out_stall;
  assign s2_load  = !s2_vld_r || s3_load;
  assign in_stall = !s2_load;
  assign out_vld  = s3_vld_r;
  assign out_vote = vote_r;

  // three compares side by side instead of a chain of swaps
  assign gt_ab = val_a > val_b;
  assign gt_bc = val_b > val_c;
  assign gt_ac = val_a > val_c;

  assign lo  = gt_ab ? (gt_bc ? val_c : val_b) : (gt_ac ? val_c : val_a);
  assign hi  = gt_ab ? (gt_ac ? val_a : val_c) : (gt_bc ? val_b : val_c);
  assign mid = gt_ab ? (gt_bc ? val_b : (gt_ac ? val_c : val_a))
                     : (gt_bc ? (gt_ac ? val_a : val_c) : val_b);

  always_comb begin
    p0_nxt       = '0;
    p1_nxt       = '0;
    p2_nxt       = '0;
    s2_scale_nxt = DIV_NONE;
    unique case (ok_mask)
      MASK_ALL: begin
        p0_nxt       = lo;
        p1_nxt       = mid;
        p2_nxt       = hi;
        s2_scale_nxt = DIV_THREE;
      end
      MASK_AB: begin
        p0_nxt       = val_a;
        p1_nxt       = val_b;
        s2_scale_nxt = DIV_TWO;
      end
      MASK_AC: begin
        p0_nxt       = val_a;
        p1_nxt       = val_c;
        s2_scale_nxt = DIV_TWO;
      end
      MASK_BC: begin
        p0_nxt       = val_b;
        p1_nxt       = val_c;
        s2_scale_nxt = DIV_TWO;
      end
      MASK_A: begin
        p0_nxt       = val_a;
        s2_scale_nxt = DIV_ONE;
      end
      MASK_B: begin
        p0_nxt       = val_b;
        s2_scale_nxt = DIV_ONE;
      end
      MASK_C: begin
        p0_nxt       = val_c;
        s2_scale_nxt = DIV_ONE;
      end
      default: s2_scale_nxt = DIV_NONE;
    endcase
  end

  // gap test on the sorted triple; low gap wins when both are too wide
  assign gap_lo  = (p1_r - p0_r) > div_limit;
  assign gap_hi  = (p2_r - p1_r) > div_limit;
  assign sum_up  = {2'b00, p1_r} + {2'b00, p2_r};
  assign sum_dn  = {2'b00, p0_r} + {2'b00, p1_r};
  assign sum_all = sum_dn + {2'b00, p2_r};

  always_comb begin
    vote_nxt.scale = s2_scale_r;
    vote_nxt.sum   = '0;
    case (s2_scale_r)
      DIV_THREE: begin
        if (gap_lo) begin
          vote_nxt.scale = DIV_TWO;
          vote_nxt.sum   = sum_up;
        end else if (gap_hi) begin
          vote_nxt.scale = DIV_TWO;
          vote_nxt.sum   = sum_dn;
        end else begin
          vote_nxt.sum   = sum_all;
        end
      end
      DIV_TWO: vote_nxt.sum = sum_dn;
      DIV_ONE: vote_nxt.sum = {2'b00, p0_r};
      default: vote_nxt.sum = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s2_load) s2_vld_r <= in_vld;
      if (s3_load) s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      p0_r       <= p0_nxt;
      p1_r       <= p1_nxt;
      p2_r       <= p2_nxt;
      s2_scale_r <= s2_scale_nxt;
    end
    if (s3_load) begin
      vote_r <= vote_nxt;
    end
  end

endmodule

[hdl/tsmv_scale.sv]
// ----------------------------------------------------------------------------
// tsmv_scale
// Output stage: divides the vote sum by one, two or three, or gives zero
// on a failed read; holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tsmv_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  output logic                       in_stall,
  input  tsmv_pkg::vote_t            vote,
  output logic                       out_vld,
  input  logic                       out_stall,
  output logic [tsmv_pkg::VAL_W-1:0] fused_r,
  output logic                       failed_r
);
  import tsmv_pkg::*;

  logic              vld_r, load;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  fused_nxt;

  assign load     = !vld_r || !out_stall;
  assign in_stall = !load;
  assign out_vld  = vld_r;

  // divide by three as a reciprocal multiply
  assign prod = {{SUM_W{1'b0}}, vote.sum} * {{SUM_W{1'b0}}, RECIP3};

  always_comb begin
    case (vote.scale)
      DIV_ONE:   fused_nxt = vote.sum[VAL_W-1:0];
      DIV_TWO:   fused_nxt = vote.sum[VAL_W:1];
      DIV_THREE: fused_nxt = prod[RECIP_SHIFT+VAL_W-1:RECIP_SHIFT];
      default:   fused_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fused_r  <= fused_nxt;
      failed_r <= (vote.scale == DIV_NONE);
    end
  end

endmodule

[hdl/tsmv_chk.sv]
// ----------------------------------------------------------------------------
// tsmv_chk
// Port-level checks on the voter, bound to the top level.
// ----------------------------------------------------------------------------
module tsmv_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [tsmv_pkg::VAL_W-1:0] out_fused_pressure,
  input logic                       out_read_failed
);
  import tsmv_pkg::*;

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a failed read always carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_failed |-> out_fused_pressure == '0)
    else $error("failed read with non-zero pressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_fused_pressure) && $stable(out_read_failed))
    else $error("stalled result changed");

endmodule

bind triple_sensor_majority_voter tsmv_chk u_tsmv_chk (.*);
